@@ hw/rtl/fpds_pkg.sv @@
// shared types, constants and pair table for the four point depth solver
package fpds_pkg;

	// field and datapath widths
	localparam int unsigned PIX_W   = 16;
	localparam int unsigned SPAN_W  = 16;
	localparam int unsigned DEPTH_W = 16;
	localparam int unsigned OUT_W   = 17;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned RAY_W   = 18;
	localparam int unsigned PT_W    = 25;
	localparam int unsigned DIFF_W  = 26;
	localparam int unsigned GRAD_W  = 32;
	localparam int unsigned MUL_W   = 33;
	localparam int unsigned PROD_W  = 66;
	localparam int unsigned NUM_W   = 64;
	localparam int unsigned DEN_W   = 32;
	localparam int unsigned QUO_W   = 33;
	localparam int unsigned RAD_W   = 64;
	localparam int unsigned ROOT_W  = 32;

	localparam int unsigned NUM_SPANS  = 6;
	localparam int unsigned NUM_POINTS = 4;
	localparam int unsigned NUM_AXES   = 3;

	// request codes
	localparam logic [1:0] REQ_SPAN  = 2'd0;
	localparam logic [1:0] REQ_PIXEL = 2'd1;
	localparam logic [1:0] REQ_SOLVE = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_DEPTH = 3'd4;

	// register reset values
	localparam logic [CFG_W-1:0] FOCAL_X_RST     = 16'd9600;
	localparam logic [CFG_W-1:0] FOCAL_Y_RST     = 16'd9600;
	localparam logic [CFG_W-1:0] CENTER_X_RST    = 16'd5120;
	localparam logic [CFG_W-1:0] CENTER_Y_RST    = 16'd3840;
	localparam logic [CFG_W-1:0] START_DEPTH_RST = 16'd10240;

	// solver constants
	localparam logic [6:0]         ITER_LAST   = 7'd99;
	localparam logic [MUL_W-1:0]   STEP_GAIN   = 33'd3277;
	localparam logic [29:0]        CONV_LIMIT  = 30'd6554;
	localparam logic [26:0]        DIST_MIN    = 27'd65;
	localparam logic [DEPTH_W-1:0] DEPTH_FLOOR = 16'd256;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic [DEN_W-1:0]        den;
	} div_cmd_t;

	typedef struct packed {
		logic                    done;
		logic signed [QUO_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic             start;
		logic [RAD_W-1:0] rad;
	} sqrt_cmd_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} sqrt_rsp_t;

	// fixed point pairs of the six spans
	function automatic logic [1:0] pair_first(input logic [2:0] p);
		logic [1:0] r;
		unique case (p)
			3'd0: r = 2'd0;
			3'd1: r = 2'd1;
			3'd2: r = 2'd2;
			3'd3: r = 2'd0;
			3'd4: r = 2'd1;
			3'd5: r = 2'd0;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] pair_second(input logic [2:0] p);
		logic [1:0] r;
		unique case (p)
			3'd0: r = 2'd1;
			3'd1: r = 2'd2;
			3'd2: r = 2'd3;
			3'd3: r = 2'd3;
			3'd4: r = 2'd3;
			3'd5: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/fpds_req_if.sv @@
// request channel: span loads, pixel loads and solve commands
interface fpds_req_if;
	import fpds_pkg::*;

	logic             valid;
	logic             ready;
	logic [1:0]       req_type;
	logic [2:0]       slot;
	logic [PIX_W-1:0] pixel_u;
	logic [PIX_W-1:0] pixel_v;
	logic [SPAN_W-1:0] span_length;

	modport source (output valid, req_type, slot, pixel_u, pixel_v, span_length, input ready);
	modport sink (input valid, req_type, slot, pixel_u, pixel_v, span_length, output ready);
endinterface

@@ hw/rtl/fpds_res_if.sv @@
// result channel: one camera-space point per transaction
interface fpds_res_if;
	import fpds_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [1:0]              point_index;
	logic signed [OUT_W-1:0] point_x;
	logic signed [OUT_W-1:0] point_y;
	logic signed [OUT_W-1:0] point_z;
	logic                    last_point;

	modport source (output valid, point_index, point_x, point_y, point_z, last_point,
		input ready);
	modport sink (input valid, point_index, point_x, point_y, point_z, last_point,
		output ready);
endinterface

@@ hw/rtl/fpds_mul.sv @@
// shared signed multiplier with registered product
module fpds_mul (
	input  logic                                  clk,
	input  logic signed [fpds_pkg::MUL_W-1:0]     a,
	input  logic signed [fpds_pkg::MUL_W-1:0]     b,
	output logic signed [fpds_pkg::PROD_W-1:0]    p
);
	import fpds_pkg::*;

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;
endmodule

@@ hw/rtl/fpds_div.sv @@
// shared signed divider, one quotient bit per cycle, truncates toward zero
module fpds_div (
	input  logic                clk,
	input  logic                arst_n,
	input  fpds_pkg::div_cmd_t  cmd,
	output fpds_pkg::div_rsp_t  rsp
);
	import fpds_pkg::*;

	localparam int unsigned STEPS = NUM_W - DEN_W;
	localparam logic [4:0] STEP_LAST = 5'(STEPS - 1);

	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  qsh_q;
	logic [DEN_W-1:0]  den_q;
	logic              neg_q;
	logic signed [QUO_W-1:0] quo_q;

	logic [NUM_W-1:0]  mag;
	logic [DEN_W:0]    trial;
	logic              ge;
	logic [DEN_W-1:0]  rem_next;
	logic [DEN_W-1:0]  q_next;

	// quotient always fits 32 bits, so the top half starts as the remainder
	assign mag      = cmd.num[NUM_W-1] ? NUM_W'(-cmd.num) : NUM_W'(cmd.num);
	assign trial    = {rem_q, qsh_q[DEN_W-1]};
	assign ge       = trial >= {1'b0, den_q};
	assign rem_next = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
	assign q_next   = {qsh_q[DEN_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= mag[NUM_W-1:DEN_W];
				qsh_q  <= mag[DEN_W-1:0];
				den_q  <= cmd.den;
				neg_q  <= cmd.num[NUM_W-1];
			end else if (busy_q) begin
				rem_q <= rem_next;
				qsh_q <= q_next;
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					quo_q  <= neg_q ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

@@ hw/rtl/fpds_sqrt.sv @@
// shared integer square root, one result bit per cycle
module fpds_sqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  fpds_pkg::sqrt_cmd_t cmd,
	output fpds_pkg::sqrt_rsp_t rsp
);
	import fpds_pkg::*;

	localparam logic [4:0] STEP_LAST = 5'(ROOT_W - 1);
	localparam logic [RAD_W-1:0] TOP_BIT = {2'b01, {(RAD_W-2){1'b0}}};

	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [RAD_W-1:0]  x_q;
	logic [RAD_W-1:0]  r_q;
	logic [RAD_W-1:0]  bitpos_q;
	logic [ROOT_W-1:0] root_q;

	logic [RAD_W-1:0]  rb;
	logic              ge;
	logic [RAD_W-1:0]  r_next;

	assign rb     = r_q + bitpos_q;
	assign ge     = x_q >= rb;
	assign r_next = ge ? ((r_q >> 1) + bitpos_q) : (r_q >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q   <= 1'b1;
				cnt_q    <= '0;
				x_q      <= cmd.rad;
				r_q      <= '0;
				bitpos_q <= TOP_BIT;
			end else if (busy_q) begin
				if (ge) begin
					x_q <= x_q - rb;
				end
				r_q      <= r_next;
				bitpos_q <= bitpos_q >> 2;
				cnt_q    <= cnt_q + 5'd1;
				if (cnt_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					root_q <= r_next[ROOT_W-1:0];
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;
endmodule

@@ hw/rtl/four_point_depth_solver.sv @@
// four point depth solver top level: sequencer, operand storage and shared units
//
// Span and pixel loads are taken in the idle state. A solve request builds a unit
// ray for each of the four pixels, sets every depth to start_depth, then runs up
// to 100 gradient steps over the six spans, stopping early once the summed span
// error drops below 0.1 cm, and returns the four camera-space points as four
// result transactions (last_point on the fourth). All arithmetic goes through one
// multiplier, one 32-step divider and one 32-step square root unit, so the time
// is set by those two iterative units: the ray setup takes five divisions and one
// square root per point and each gradient step six square roots and up to twelve
// divisions. The request channel is not ready while a solve is running.
module four_point_depth_solver (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fpds_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [fpds_pkg::CFG_W-1:0]         cfg_wdata,
	fpds_req_if.sink                           req,
	fpds_res_if.source                         res
);
	import fpds_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_MULW, S_DIVW, S_SQW,
		R_A, R_B, R_SQA, R_SQB, R_RAD, R_M, R_RX, R_RY, R_RZ,
		L_PT, L_PT2, L_DA, L_DB, L_SQ, L_SQ2, L_ERR, L_DOT, L_DOT2, L_GQ, L_GA,
		L_NEXTP, L_UP, L_UP2, L_CHK,
		O_ISS, O_MUL2, O_WAIT
	} state_t;

	// control
	state_t     st_q;
	state_t     ret_q;
	logic [1:0] k_q;
	logic [1:0] c_q;
	logic [2:0] p_q;
	logic [6:0] it_q;
	logic       side_q;

	// configuration
	logic [CFG_W-1:0] fx_q;
	logic [CFG_W-1:0] fy_q;
	logic [CFG_W-1:0] cx_q;
	logic [CFG_W-1:0] cy_q;
	logic [CFG_W-1:0] sd_q;

	// storage
	logic [SPAN_W-1:0]        span_q  [NUM_SPANS];
	logic [PIX_W-1:0]         pu_q    [NUM_POINTS];
	logic [PIX_W-1:0]         pv_q    [NUM_POINTS];
	logic signed [RAY_W-1:0]  ray_q   [NUM_POINTS][NUM_AXES];
	logic [DEPTH_W-1:0]       depth_q [NUM_POINTS];
	logic signed [PT_W-1:0]   pt_q    [NUM_POINTS][NUM_AXES];
	logic signed [GRAD_W-1:0] grad_q  [NUM_POINTS];
	logic signed [DIFF_W-1:0] d_q     [NUM_AXES];

	// working registers
	logic signed [31:0]       a_q;
	logic signed [31:0]       b_q;
	logic [RAD_W-1:0]         acc_q;
	logic [ROOT_W-1:0]        m_q;
	logic signed [PT_W-1:0]   tmp_q;
	logic [52:0]              sq_q;
	logic [26:0]              dist_q;
	logic signed [27:0]       err_q;
	logic [29:0]              total_q;
	logic signed [45:0]       dot_q;
	logic signed [MUL_W-1:0]  ma_q;
	logic signed [MUL_W-1:0]  mb_q;
	div_cmd_t                 div_cmd_q;
	sqrt_cmd_t                sqrt_cmd_q;

	// result register
	logic                    res_valid_q;
	logic [1:0]              pidx_q;
	logic signed [OUT_W-1:0] px_q;
	logic signed [OUT_W-1:0] py_q;
	logic signed [OUT_W-1:0] pz_q;
	logic                    plast_q;

	// shared units
	logic signed [PROD_W-1:0] mul_p;
	div_rsp_t                 div_rsp;
	sqrt_rsp_t                sqrt_rsp;

	fpds_mul u_mul (.clk(clk), .a(ma_q), .b(mb_q), .p(mul_p));
	fpds_div u_div (.clk(clk), .arst_n(arst_n), .cmd(div_cmd_q), .rsp(div_rsp));
	fpds_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .cmd(sqrt_cmd_q), .rsp(sqrt_rsp));

	// signed shift right that rounds toward zero
	function automatic logic signed [PROD_W-1:0] shr_trunc(
		input logic signed [PROD_W-1:0] v, input logic [5:0] sh);
		logic [PROD_W-1:0]        one_sh;
		logic signed [PROD_W-1:0] bias;
		one_sh = {{(PROD_W-1){1'b0}}, 1'b1} << sh;
		bias   = v[PROD_W-1] ? $signed(one_sh - {{(PROD_W-1){1'b0}}, 1'b1}) : '0;
		return (v + bias) >>> sh;
	endfunction

	// ratio saturation to +/-(2^31-1)
	function automatic logic signed [31:0] sat32(input logic signed [QUO_W-1:0] q);
		logic signed [31:0] r;
		if (q > $signed(33'h0_7FFF_FFFF)) begin
			r = 32'sh7FFF_FFFF;
		end else if (q < -$signed(33'h0_7FFF_FFFF)) begin
			r = 32'sh8000_0001;
		end else begin
			r = q[31:0];
		end
		return r;
	endfunction

	// pair decode and single read port per array
	logic [1:0] pi;
	logic [1:0] pj;
	logic [1:0] side_k;
	logic [1:0] ray_k;
	logic [1:0] pt_k;
	logic [1:0] grad_k;
	logic signed [RAY_W-1:0]  ray_rd;
	logic signed [PT_W-1:0]   pt_rd;
	logic signed [GRAD_W-1:0] grad_rd;
	logic [DEPTH_W-1:0]       depth_rd;
	logic [SPAN_W-1:0]        span_rd;
	logic signed [DIFF_W-1:0] d_rd;

	assign pi       = pair_first(p_q);
	assign pj       = pair_second(p_q);
	assign side_k   = side_q ? pj : pi;
	assign ray_k    = (st_q == L_DOT) ? side_k : k_q;
	assign pt_k     = (st_q == L_DB) ? pj : pi;
	assign grad_k   = (st_q == L_GA) ? side_k : k_q;
	assign ray_rd   = ray_q[ray_k][c_q];
	assign pt_rd    = pt_q[pt_k][c_q];
	assign grad_rd  = grad_q[grad_k];
	assign depth_rd = depth_q[k_q];
	assign span_rd  = span_q[p_q];
	assign d_rd     = d_q[c_q];

	// ray setup operands
	logic signed [16:0]      u_diff;
	logic signed [16:0]      v_diff;
	logic [DEN_W-1:0]        fx_eff;
	logic [DEN_W-1:0]        fy_eff;
	assign u_diff = $signed({1'b0, pu_q[k_q]}) - $signed({1'b0, cx_q});
	assign v_diff = $signed({1'b0, pv_q[k_q]}) - $signed({1'b0, cy_q});
	// a focal length of zero acts as one
	assign fx_eff = (fx_q == '0) ? 32'd1 : {16'b0, fx_q};
	assign fy_eff = (fy_q == '0) ? 32'd1 : {16'b0, fy_q};

	// span error and its magnitude
	logic signed [27:0] err_w;
	logic [27:0]        err_abs;
	assign err_w   = $signed({1'b0, sqrt_rsp.root[26:0]}) - $signed({4'b0, span_rd, 8'b0});
	assign err_abs = err_w[27] ? 28'(-err_w) : 28'(err_w);

	// dot product of the pair difference with one ray, scaled down by 2^16
	logic signed [45:0]       dot_full;
	logic signed [45:0]       dot_side;
	logic signed [PROD_W-1:0] dot_t;
	assign dot_full = dot_q + mul_p[45:0];
	assign dot_side = side_q ? -dot_full : dot_full;
	assign dot_t    = shr_trunc({{(PROD_W-46){dot_side[45]}}, dot_side}, 6'd16);

	// point on ray, depth update and output scaling
	logic signed [PROD_W-1:0] pt_t;
	logic signed [PROD_W-1:0] step_t;
	logic signed [PROD_W-1:0] out_t;
	logic signed [23:0]       nd;
	logic [DEPTH_W-1:0]       nd_clamped;
	assign pt_t   = shr_trunc(mul_p, 6'd8);
	assign step_t = shr_trunc(mul_p, 6'd24);
	assign out_t  = shr_trunc(mul_p, 6'd16);
	assign nd     = $signed({8'b0, depth_rd}) - step_t[23:0];
	always_comb begin
		if (nd < $signed({8'b0, DEPTH_FLOOR})) begin
			nd_clamped = DEPTH_FLOOR;
		end else if (nd > 24'sd65535) begin
			nd_clamped = '1;
		end else begin
			nd_clamped = nd[DEPTH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			ret_q       <= S_IDLE;
			k_q         <= '0;
			c_q         <= '0;
			p_q         <= '0;
			it_q        <= '0;
			side_q      <= 1'b0;
			fx_q        <= FOCAL_X_RST;
			fy_q        <= FOCAL_Y_RST;
			cx_q        <= CENTER_X_RST;
			cy_q        <= CENTER_Y_RST;
			sd_q        <= START_DEPTH_RST;
			div_cmd_q   <= '0;
			sqrt_cmd_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			div_cmd_q.start  <= 1'b0;
			sqrt_cmd_q.start <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_idx)
					REG_FOCAL_X:     fx_q <= cfg_wdata;
					REG_FOCAL_Y:     fy_q <= cfg_wdata;
					REG_CENTER_X:    cx_q <= cfg_wdata;
					REG_CENTER_Y:    cy_q <= cfg_wdata;
					REG_START_DEPTH: sd_q <= cfg_wdata;
					default: ;
				endcase
			end

			unique case (st_q)
				S_IDLE: begin
					if (req.valid) begin
						unique case (req.req_type)
							REQ_SPAN: begin
								if (req.slot < 3'(NUM_SPANS)) begin
									span_q[req.slot] <= req.span_length;
								end
							end
							REQ_PIXEL: begin
								if (req.slot < 3'(NUM_POINTS)) begin
									pu_q[req.slot[1:0]] <= req.pixel_u;
									pv_q[req.slot[1:0]] <= req.pixel_v;
								end
							end
							REQ_SOLVE: begin
								k_q  <= '0;
								st_q <= R_A;
							end
							default: ;
						endcase
					end
				end

				// wait states return to the caller
				S_MULW: st_q <= ret_q;
				S_DIVW: begin
					if (div_rsp.done) st_q <= ret_q;
				end
				S_SQW: begin
					if (sqrt_rsp.done) st_q <= ret_q;
				end

				// ray setup for point k
				R_A: begin
					div_cmd_q <= '{start: 1'b1, num: {{31{u_diff[16]}}, u_diff, 16'b0},
						den: fx_eff};
					ret_q <= R_B;
					st_q  <= S_DIVW;
				end
				R_B: begin
					a_q <= sat32(div_rsp.quo);
					div_cmd_q <= '{start: 1'b1, num: {{31{v_diff[16]}}, v_diff, 16'b0},
						den: fy_eff};
					ret_q <= R_SQA;
					st_q  <= S_DIVW;
				end
				R_SQA: begin
					b_q   <= sat32(div_rsp.quo);
					ma_q  <= {a_q[31], a_q};
					mb_q  <= {a_q[31], a_q};
					ret_q <= R_SQB;
					st_q  <= S_MULW;
				end
				R_SQB: begin
					acc_q <= mul_p[RAD_W-1:0];
					ma_q  <= {b_q[31], b_q};
					mb_q  <= {b_q[31], b_q};
					ret_q <= R_RAD;
					st_q  <= S_MULW;
				end
				R_RAD: begin
					sqrt_cmd_q <= '{start: 1'b1,
						rad: acc_q + mul_p[RAD_W-1:0] + 64'h1_0000_0000};
					ret_q <= R_M;
					st_q  <= S_SQW;
				end
				R_M: begin
					m_q <= sqrt_rsp.root;
					div_cmd_q <= '{start: 1'b1, num: {{16{a_q[31]}}, a_q, 16'b0},
						den: sqrt_rsp.root};
					ret_q <= R_RX;
					st_q  <= S_DIVW;
				end
				R_RX: begin
					ray_q[k_q][0] <= div_rsp.quo[RAY_W-1:0];
					div_cmd_q <= '{start: 1'b1, num: {{16{b_q[31]}}, b_q, 16'b0}, den: m_q};
					ret_q <= R_RY;
					st_q  <= S_DIVW;
				end
				R_RY: begin
					ray_q[k_q][1] <= div_rsp.quo[RAY_W-1:0];
					div_cmd_q <= '{start: 1'b1, num: 64'sh1_0000_0000, den: m_q};
					ret_q <= R_RZ;
					st_q  <= S_DIVW;
				end
				R_RZ: begin
					ray_q[k_q][2] <= div_rsp.quo[RAY_W-1:0];
					depth_q[k_q]  <= sd_q;
					if (k_q == 2'd3) begin
						it_q <= '0;
						k_q  <= '0;
						c_q  <= '0;
						st_q <= L_PT;
					end else begin
						k_q  <= k_q + 2'd1;
						st_q <= R_A;
					end
				end

				// points on rays at the current depths
				L_PT: begin
					ma_q  <= {{(MUL_W-RAY_W){ray_rd[RAY_W-1]}}, ray_rd};
					mb_q  <= {{(MUL_W-DEPTH_W){1'b0}}, depth_rd};
					ret_q <= L_PT2;
					st_q  <= S_MULW;
				end
				L_PT2: begin
					pt_q[k_q][c_q] <= pt_t[PT_W-1:0];
					if (c_q == 2'd2) begin
						c_q <= '0;
						if (k_q == 2'd3) begin
							k_q     <= '0;
							p_q     <= '0;
							total_q <= '0;
							grad_q  <= '{default: '0};
							st_q    <= L_DA;
						end else begin
							k_q  <= k_q + 2'd1;
							st_q <= L_PT;
						end
					end else begin
						c_q  <= c_q + 2'd1;
						st_q <= L_PT;
					end
				end

				// pair difference, one axis per pass through L_DA and L_DB
				L_DA: begin
					tmp_q <= pt_rd;
					st_q  <= L_DB;
				end
				L_DB: begin
					d_q[c_q] <= {tmp_q[PT_W-1], tmp_q} - {pt_rd[PT_W-1], pt_rd};
					if (c_q == 2'd2) begin
						c_q  <= '0;
						sq_q <= '0;
						st_q <= L_SQ;
					end else begin
						c_q  <= c_q + 2'd1;
						st_q <= L_DA;
					end
				end

				// squared distance, then root
				L_SQ: begin
					ma_q  <= {{(MUL_W-DIFF_W){d_rd[DIFF_W-1]}}, d_rd};
					mb_q  <= {{(MUL_W-DIFF_W){d_rd[DIFF_W-1]}}, d_rd};
					ret_q <= L_SQ2;
					st_q  <= S_MULW;
				end
				L_SQ2: begin
					if (c_q == 2'd2) begin
						c_q <= '0;
						sqrt_cmd_q <= '{start: 1'b1, rad: {11'b0, sq_q + mul_p[52:0]}};
						ret_q <= L_ERR;
						st_q  <= S_SQW;
					end else begin
						sq_q <= sq_q + mul_p[52:0];
						c_q  <= c_q + 2'd1;
						st_q <= L_SQ;
					end
				end
				L_ERR: begin
					dist_q  <= sqrt_rsp.root[26:0];
					err_q   <= err_w;
					total_q <= total_q + {2'b0, err_abs};
					// pairs that nearly coincide add no gradient
					if (sqrt_rsp.root[26:0] > DIST_MIN) begin
						c_q    <= '0;
						side_q <= 1'b0;
						dot_q  <= '0;
						st_q   <= L_DOT;
					end else begin
						st_q <= L_NEXTP;
					end
				end

				// gradient terms for first then second point of the pair
				L_DOT: begin
					ma_q  <= {{(MUL_W-DIFF_W){d_rd[DIFF_W-1]}}, d_rd};
					mb_q  <= {{(MUL_W-RAY_W){ray_rd[RAY_W-1]}}, ray_rd};
					ret_q <= L_DOT2;
					st_q  <= S_MULW;
				end
				L_DOT2: begin
					if (c_q == 2'd2) begin
						c_q   <= '0;
						ma_q  <= {{(MUL_W-28){err_q[27]}}, err_q};
						mb_q  <= dot_t[MUL_W-1:0];
						ret_q <= L_GQ;
						st_q  <= S_MULW;
					end else begin
						dot_q <= dot_full;
						c_q   <= c_q + 2'd1;
						st_q  <= L_DOT;
					end
				end
				L_GQ: begin
					div_cmd_q <= '{start: 1'b1, num: mul_p[NUM_W-1:0], den: {5'b0, dist_q}};
					ret_q <= L_GA;
					st_q  <= S_DIVW;
				end
				L_GA: begin
					grad_q[side_k] <= grad_rd + div_rsp.quo[GRAD_W-1:0];
					if (!side_q) begin
						side_q <= 1'b1;
						c_q    <= '0;
						dot_q  <= '0;
						st_q   <= L_DOT;
					end else begin
						st_q <= L_NEXTP;
					end
				end
				L_NEXTP: begin
					if (p_q == 3'(NUM_SPANS - 1)) begin
						k_q  <= '0;
						st_q <= L_UP;
					end else begin
						p_q  <= p_q + 3'd1;
						c_q  <= '0;
						st_q <= L_DA;
					end
				end

				// depth update with floor and ceiling
				L_UP: begin
					ma_q  <= {grad_rd[GRAD_W-1], grad_rd};
					mb_q  <= STEP_GAIN;
					ret_q <= L_UP2;
					st_q  <= S_MULW;
				end
				L_UP2: begin
					depth_q[k_q] <= nd_clamped;
					if (k_q == 2'd3) begin
						st_q <= L_CHK;
					end else begin
						k_q  <= k_q + 2'd1;
						st_q <= L_UP;
					end
				end
				L_CHK: begin
					k_q <= '0;
					c_q <= '0;
					if ((total_q < CONV_LIMIT) || (it_q == ITER_LAST)) begin
						st_q <= O_ISS;
					end else begin
						it_q <= it_q + 7'd1;
						st_q <= L_PT;
					end
				end

				// final points, one result transaction each
				O_ISS: begin
					ma_q  <= {{(MUL_W-RAY_W){ray_rd[RAY_W-1]}}, ray_rd};
					mb_q  <= {{(MUL_W-DEPTH_W){1'b0}}, depth_rd};
					ret_q <= O_MUL2;
					st_q  <= S_MULW;
				end
				O_MUL2: begin
					if (c_q == 2'd0) begin
						px_q <= out_t[OUT_W-1:0];
					end else if (c_q == 2'd1) begin
						py_q <= out_t[OUT_W-1:0];
					end else begin
						pz_q <= out_t[OUT_W-1:0];
					end
					pidx_q  <= k_q;
					plast_q <= (k_q == 2'd3);
					if (c_q == 2'd2) begin
						res_valid_q <= 1'b1;
						st_q        <= O_WAIT;
					end else begin
						c_q  <= c_q + 2'd1;
						st_q <= O_ISS;
					end
				end
				O_WAIT: begin
					if (res.ready) begin
						res_valid_q <= 1'b0;
						c_q         <= '0;
						if (k_q == 2'd3) begin
							st_q <= S_IDLE;
						end else begin
							k_q  <= k_q + 2'd1;
							st_q <= O_ISS;
						end
					end
				end

				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready       = (st_q == S_IDLE);
	assign res.valid       = res_valid_q;
	assign res.point_index = pidx_q;
	assign res.point_x     = px_q;
	assign res.point_y     = py_q;
	assign res.point_z     = pz_q;
	assign res.last_point  = plast_q;
endmodule

@@ dv/four_point_depth_solver_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the four point depth solver, with scoreboard and predictor
module four_point_depth_solver_tb;
	import fpds_pkg::*;

	// request code the block ignores
	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int RAND_ITEMS = 100;
	localparam int HOLD_CYCLES = 2500;

	typedef struct {
		logic [1:0]        kind;
		logic [2:0]        slot;
		logic [PIX_W-1:0]  u;
		logic [PIX_W-1:0]  v;
		logic [SPAN_W-1:0] span;
	} request_t;

	typedef struct {
		logic [1:0]       idx;
		logic [OUT_W-1:0] x;
		logic [OUT_W-1:0] y;
		logic [OUT_W-1:0] z;
		logic             last;
	} point_t;

	// predicts the solver's camera-space points and checks them in order
	class depth_scoreboard;
		longint focal_x, focal_y, center_x, center_y, start_depth;
		longint spans[NUM_SPANS];
		longint pix_u[NUM_POINTS], pix_v[NUM_POINTS];
		longint ray[NUM_POINTS][NUM_AXES];
		longint depth[NUM_POINTS];
		point_t expected_points[$];
		int errors, results_seen, solves_seen, loads_seen;

		function new();
			focal_x = FOCAL_X_RST;
			focal_y = FOCAL_Y_RST;
			center_x = CENTER_X_RST;
			center_y = CENTER_Y_RST;
			start_depth = START_DEPTH_RST;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_FOCAL_X: focal_x = val;
				REG_FOCAL_Y: focal_y = val;
				REG_CENTER_X: center_x = val;
				REG_CENTER_Y: center_y = val;
				REG_START_DEPTH: start_depth = val;
				default: ;
			endcase
		endfunction

		function longint unsigned int_sqrt(longint unsigned x);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > x) b = b >> 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else
					r = r >> 1;
				b = b >> 2;
			end
			return r;
		endfunction

		function longint clip_ratio(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483647) return -64'sd2147483647;
			return v;
		endfunction

		function void solve_depths();
			longint fx, fy, a, b, m, pt[NUM_POINTS][NUM_AXES], grad[NUM_POINTS];
			longint total, d[NUM_AXES], di, dj, err, pair_len, nd;
			longint unsigned sq;
			int i, j;
			fx = (focal_x == 0) ? 1 : focal_x;
			fy = (focal_y == 0) ? 1 : focal_y;
			for (int k = 0; k < NUM_POINTS; k++) begin
				a = clip_ratio((pix_u[k] - center_x) * 65536 / fx);
				b = clip_ratio((pix_v[k] - center_y) * 65536 / fy);
				m = int_sqrt(a * a + b * b + (64'd1 << 32));
				ray[k][0] = a * 65536 / m;
				ray[k][1] = b * 65536 / m;
				ray[k][2] = (64'sd1 << 32) / m;
				depth[k] = start_depth;
			end
			for (int it = 0; it <= ITER_LAST; it++) begin
				total = 0;
				for (int k = 0; k < NUM_POINTS; k++) begin
					grad[k] = 0;
					for (int c = 0; c < NUM_AXES; c++)
						pt[k][c] = ray[k][c] * depth[k] / 256;
				end
				for (int p = 0; p < NUM_SPANS; p++) begin
					i = int'(pair_first(3'(p)));
					j = int'(pair_second(3'(p)));
					sq = 0;
					di = 0;
					dj = 0;
					for (int c = 0; c < NUM_AXES; c++) begin
						d[c] = pt[i][c] - pt[j][c];
						sq += d[c] * d[c];
					end
					pair_len = int_sqrt(sq);
					err = pair_len - spans[p] * 256;
					total += (err < 0) ? -err : err;
					// coincident points give no gradient
					if (pair_len > 65) begin
						for (int c = 0; c < NUM_AXES; c++) begin
							di += d[c] * ray[i][c];
							dj -= d[c] * ray[j][c];
						end
						grad[i] += err * (di / 65536) / pair_len;
						grad[j] += err * (dj / 65536) / pair_len;
					end
				end
				for (int k = 0; k < NUM_POINTS; k++) begin
					nd = depth[k] - grad[k] * 3277 / (64'sd1 << 24);
					if (nd < 256) nd = 256;
					if (nd > 65535) nd = 65535;
					depth[k] = nd;
				end
				if (total < 6554) break;
			end
		endfunction

		function void note_request(request_t r);
			point_t e;
			longint q;
			case (r.kind)
				REQ_SPAN: if (r.slot < NUM_SPANS) begin
					spans[r.slot] = r.span;
					loads_seen++;
				end
				REQ_PIXEL: if (r.slot < NUM_POINTS) begin
					pix_u[r.slot] = r.u;
					pix_v[r.slot] = r.v;
					loads_seen++;
				end
				REQ_SOLVE: begin
					solve_depths();
					solves_seen++;
					for (int k = 0; k < NUM_POINTS; k++) begin
						e.idx = 2'(k);
						q = ray[k][0] * depth[k] / 65536;
						e.x = q[OUT_W-1:0];
						q = ray[k][1] * depth[k] / 65536;
						e.y = q[OUT_W-1:0];
						q = ray[k][2] * depth[k] / 65536;
						e.z = q[OUT_W-1:0];
						e.last = (k == NUM_POINTS - 1);
						expected_points = {expected_points, e};
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(point_t a);
			point_t e;
			results_seen++;
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected point idx=%0d x=%h y=%h z=%h", $time,
					a.idx, a.x, a.y, a.z);
				errors++;
				return;
			end
			e = expected_points.pop_front();
			if (a.idx !== e.idx) begin
				$display("%0t: point_index exp %0d got %0d", $time, e.idx, a.idx);
				errors++;
			end
			if (a.x !== e.x) begin
				$display("%0t: point_x exp %h got %h", $time, e.x, a.x);
				errors++;
			end
			if (a.y !== e.y) begin
				$display("%0t: point_y exp %h got %h", $time, e.y, a.y);
				errors++;
			end
			if (a.z !== e.z) begin
				$display("%0t: point_z exp %h got %h", $time, e.z, a.z);
				errors++;
			end
			if (a.last !== e.last) begin
				$display("%0t: last_point exp %0d got %0d", $time, e.last, a.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;

	fpds_req_if req ();
	fpds_res_if res ();

	four_point_depth_solver dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.req(req),
		.res(res)
	);

	depth_scoreboard depth_sb = new();

	// both sides drop idling while this is set
	bit steady;
	// set once the long receiver hold-off has happened
	bit hold_done;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// generous ceiling: every solve at its full 100 steps, plus stalls
	initial begin
		#400ms;
		$display("four_point_depth_solver_tb: FAIL");
		$finish;
	end

	// result side: random back-pressure, with one long hold-off while results wait
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && res.valid && req.valid && depth_sb.solves_seen > 4) begin
				hold_done = 1'b1;
				res.ready <= 1'b0;
				// the sender keeps offering transactions meanwhile
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			res.ready <= steady || ($urandom_range(99) >= 7);
		end
	end

	always @(posedge clk) begin
		point_t got;
		if (arst_n && res.valid && res.ready) begin
			got.idx = res.point_index;
			got.x = res.point_x;
			got.y = res.point_y;
			got.z = res.point_z;
			got.last = res.last_point;
			depth_sb.check_result(got);
		end
	end

	// one request transaction, with random idle cycles in front
	task automatic send_request(request_t r);
		while (!steady && $urandom_range(99) < 7) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= r.kind;
		req.slot <= r.slot;
		req.pixel_u <= r.u;
		req.pixel_v <= r.v;
		req.span_length <= r.span;
		do @(posedge clk); while (!req.ready);
		depth_sb.note_request(r);
		@(negedge clk);
	endtask

	task automatic send_span(int s, logic [SPAN_W-1:0] len);
		request_t r;
		r = '{kind: REQ_SPAN, slot: 3'(s), u: 16'($urandom), v: 16'($urandom), span: len};
		send_request(r);
	endtask

	task automatic send_pixel(int s, logic [PIX_W-1:0] u, logic [PIX_W-1:0] v);
		request_t r;
		r = '{kind: REQ_PIXEL, slot: 3'(s), u: u, v: v, span: 16'($urandom)};
		send_request(r);
	endtask

	task automatic send_solve();
		request_t r;
		r = '{kind: REQ_SOLVE, slot: 3'($urandom), u: 16'($urandom), v: 16'($urandom),
			span: 16'($urandom)};
		send_request(r);
	endtask

	// registers change only with nothing in flight
	task automatic wait_idle();
		req.valid <= 1'b0;
		@(negedge clk);
		while (depth_sb.expected_points.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		depth_sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic write_all(logic [CFG_W-1:0] fx, logic [CFG_W-1:0] fy,
		logic [CFG_W-1:0] cx, logic [CFG_W-1:0] cy, logic [CFG_W-1:0] sd);
		wait_idle();
		write_reg(REG_FOCAL_X, fx);
		write_reg(REG_FOCAL_Y, fy);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_START_DEPTH, sd);
		cfg_we <= 1'b0;
	endtask

	initial begin
		request_t r;
		int n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.req_type = REQ_SPAN;
		req.slot = '0;
		req.pixel_u = '0;
		req.pixel_v = '0;
		req.span_length = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: span extremes, pixel extremes, default registers
		send_span(0, 16'h0000);
		send_span(1, 16'hFFFF);
		send_span(2, 16'd2560);
		send_span(3, 16'd5120);
		send_span(4, 16'd3000);
		send_span(5, 16'd4000);
		send_pixel(0, 16'h0000, 16'h0000);
		send_pixel(1, 16'hFFFF, 16'hFFFF);
		send_pixel(2, CENTER_X_RST, CENTER_Y_RST);
		send_pixel(3, 16'd6000, 16'd3000);
		// out of range slots and the unused request code are dropped
		send_span(6, 16'd1);
		send_pixel(4, 16'd1, 16'd1);
		send_pixel(7, 16'd2, 16'd2);
		r = '{kind: REQ_NONE, slot: 3'd0, u: 16'hFFFF, v: 16'hFFFF, span: 16'hFFFF};
		send_request(r);
		send_solve();
		// all pixels on one spot: zero distances, no gradient
		for (int k = 0; k < NUM_POINTS; k++) send_pixel(k, 16'd5000, 16'd4000);
		for (int s = 0; s < NUM_SPANS; s++) send_span(s, 16'h0000);
		send_solve();

		// zero focal length and a start depth below the floor
		write_all(16'h0000, 16'd1, 16'hFFFF, 16'h0000, 16'd100);
		send_pixel(0, 16'h0000, 16'hFFFF);
		send_pixel(1, 16'hFFFF, 16'h0000);
		send_solve();
		// widest focal lengths, deepest start
		write_all(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
		send_solve();

		write_all(16'($urandom_range(20000, 4000)), 16'($urandom_range(20000, 4000)),
			16'($urandom), 16'($urandom), 16'($urandom_range(65535, 256)));
		n = 0;
		while (n < RAND_ITEMS) begin
			steady = (n >= 40 && n < 60);
			if (n == 60)
				write_all(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
					16'($urandom), 16'($urandom), 16'($urandom_range(65535, 256)));
			case ($urandom_range(99)) inside
				[0:7]: send_solve();
				[8:11]: begin
					r = '{kind: REQ_NONE, slot: 3'($urandom), u: 16'($urandom),
						v: 16'($urandom), span: 16'($urandom)};
					send_request(r);
				end
				[12:55]: send_span($urandom_range(7), 16'($urandom));
				default: send_pixel($urandom_range(7), 16'($urandom), 16'($urandom));
			endcase
			n++;
		end
		steady = 1'b0;
		send_solve();
		req.valid <= 1'b0;

		while (depth_sb.expected_points.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		$display("covered %0d loads and %0d solves over five register settings",
			depth_sb.loads_seen, depth_sb.solves_seen);
		$display("checked %0d points, %0d mismatches", depth_sb.results_seen,
			depth_sb.errors);
		if (depth_sb.errors == 0)
			$display("four_point_depth_solver_tb: PASS");
		else
			$display("four_point_depth_solver_tb: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/fpds_pkg.sv
hw/rtl/fpds_req_if.sv
hw/rtl/fpds_res_if.sv
hw/rtl/fpds_mul.sv
hw/rtl/fpds_div.sv
hw/rtl/fpds_sqrt.sv
hw/rtl/four_point_depth_solver.sv
dv/four_point_depth_solver_tb.sv
